// ===== rtl/sfd_pkg.sv =====
`default_nettype none
package sfd_pkg;

  localparam int unsigned FRAME_LEN  = 31;
  localparam int unsigned NUM_WORDS  = 6;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned WORD_IDX_W = 3;

  localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
  localparam logic [POS_W-1:0] POS_FIRST  = 5'd1;
  localparam logic [POS_W-1:0] POS_IDX_HI = 5'd3;
  localparam logic [POS_W-1:0] POS_IDX_LO = 5'd4;
  localparam logic [POS_W-1:0] POS_WORD0  = 5'd5;
  localparam logic [POS_W-1:0] POS_WORDN  = 5'd28;
  localparam logic [POS_W-1:0] POS_CSUM   = 5'd29;
  localparam logic [POS_W-1:0] POS_TAIL   = 5'd30;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 8'd1;

  localparam logic [7:0] HEADER_RST = 8'h55;
  localparam logic [7:0] TAIL_RST   = 8'hAA;

  localparam int unsigned OUT_DATA_W = 16 + 32 * NUM_WORDS;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_CSUM = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t   status;
    logic [5:0][31:0] words;
    logic [15:0]     frame_index;
  } sfd_result_t;

  typedef struct packed {
    logic valid;
    logic free;
  } sfd_out_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sfd_parser.sv =====
`default_nettype none
module sfd_parser
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  input  wire logic [7:0]  header_byte,
  input  wire logic [7:0]  tail_byte,
  output logic             is_tail,
  output sfd_result_t      result
);

  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic [15:0]           idx_r, idx_nxt;
  logic [7:0]            csum_r;
  logic [31:0]           words_r [NUM_WORDS];
  logic [POS_W-1:0]      off;
  logic [WORD_IDX_W-1:0] w_idx;
  logic [1:0]            b_sel;
  logic                  in_words;

  assign off      = pos_r - POS_WORD0;
  assign w_idx    = off[4:2];
  assign b_sel    = off[1:0];
  assign in_words = pos_r inside {[POS_WORD0:POS_WORDN]};
  assign is_tail  = (pos_r == POS_TAIL);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    idx_nxt = idx_r;
    if (pos_r == POS_HUNT) begin
      if (byte_in == header_byte) begin
        pos_nxt = POS_FIRST;
        sum_nxt = 8'd0;
      end
    end else begin
      if (pos_r == POS_IDX_HI) begin
        idx_nxt = {byte_in, idx_r[7:0]};
      end else if (pos_r == POS_IDX_LO) begin
        idx_nxt = {idx_r[15:8], byte_in};
      end else if (in_words) begin
        sum_nxt = sum_r + byte_in;
      end
      pos_nxt = is_tail ? POS_HUNT : pos_r + POS_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= 8'd0;
      idx_r <= 16'd0;
    end else if (step) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_words) begin
      words_r[w_idx][{b_sel, 3'b000} +: 8] <= byte_in;
    end
    if (step && pos_r == POS_CSUM) begin
      csum_r <= byte_in;
    end
  end

  always_comb begin
    result.frame_index = idx_r;
    for (int k = 0; k < NUM_WORDS; k++) begin
      result.words[k] = words_r[k];
    end
    if (byte_in != tail_byte) begin
      result.status = ST_BAD_TAIL;
    end else if (csum_r != sum_r) begin
      result.status = ST_BAD_CSUM;
    end else begin
      result.status = ST_OK;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfd_out_reg.sv =====
`default_nettype none
module sfd_out_reg
  import sfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire sfd_result_t           result,
  input  wire logic                  out_tready,
  output sfd_out_stat_t              stat,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                 out_tuser
);

  logic        valid_r;
  sfd_result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign stat.valid = valid_r;
  assign stat.free  = !valid_r || out_tready;
  assign out_tdata  = {res_r.words, res_r.frame_index};
  assign out_tuser  = res_r.status;

endmodule
`default_nettype wire

// ===== rtl/sensor_frame_deframer.sv =====
// Sensor frame deframer.
// in_*  : one received byte per beat (in_tdata). Bytes are dropped until the
//         header byte is seen; the next 30 bytes are taken by position.
// out_* : one beat per frame, emitted at the tail position, good or bad.
//         out_tuser carries the status: 0 ok, 1 bad tail, 2 bad checksum.
// cfg_* : register writes (0 header byte, 1 tail byte), always ready; write
//         only while no frame is in flight. Other indexes are ignored.
// Throughput: one byte per cycle unless a tail byte waits on a held result; set
// by the single byte register feeding the position counter and capture logic.
// Result path: the tail beat passes through the input register, then the
// result register, which holds the frame result shown on out_*.
// Stall: the result register holds the frame while out_tready is low; bytes
// keep flowing until a second tail byte reaches the input register, which
// then waits and drops in_tready.
// Reset: hunting for a header, no result pending, header 0x55, tail 0xAA.
`default_nettype none
module sensor_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // rx_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // frame_index[15:0], force_x, force_y, force_z, torque_x, torque_y, torque_z
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                 out_tuser,  // frame_status
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]            cfg_data
);

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic [7:0]    header_r;
  logic [7:0]    tail_r;
  logic          is_tail;
  logic          advance;
  sfd_result_t   result;
  sfd_out_stat_t ostat;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!is_tail || ostat.free);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      tail_r   <= TAIL_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEADER) begin
        header_r <= cfg_data;
      end else if (cfg_index == REG_TAIL) begin
        tail_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  sfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .byte_in     (in_byte_r),
    .header_byte (header_r),
    .tail_byte   (tail_r),
    .is_tail     (is_tail),
    .result      (result)
  );

  sfd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && is_tail),
    .result     (result),
    .out_tready (out_tready),
    .stat       (ostat),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign out_tvalid = ostat.valid;

endmodule
`default_nettype wire

// ===== rtl/sfd_checker.sv =====
`default_nettype none
module sfd_checker
  import sfd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]           out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined frame status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 200;

  typedef struct packed {
    logic             lead_tail;
    logic [3:0]       pre;
    logic [15:0]      idx;
    logic [5:0][31:0] words;
    logic [7:0]       csum_delta;
    logic [7:0]       tail_flip;
    logic             typed;
    frame_status_t    status;
  } frame_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // rx_byte
  logic                  out_tvalid;
  logic                  out_tready;
  // frame_index, force_x, force_y, force_z, torque_x, torque_y, torque_z
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;  // frame_status
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [7:0]            cfg_data;

  // frame recovery state as the block should hold it
  logic [7:0]       hdr_val  = HEADER_RST;
  logic [7:0]       tail_val = TAIL_RST;
  logic [POS_W-1:0] fr_pos   = POS_HUNT;
  logic [7:0]       fr_sum   = '0;
  logic [15:0]      fr_index = '0;
  logic [5:0][31:0] fr_words = '0;
  logic [7:0]       fr_csum  = '0;

  sfd_result_t pending_frames [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          bytes_sent  = 0;
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  bit          hold_req    = 1'b0;

  string word_names [0:5] = '{"force_x_bits", "force_y_bits", "force_z_bits",
                              "torque_x_bits", "torque_y_bits", "torque_z_bits"};

  frame_row_t directed_rows [0:7] = '{
    '{1'b0, 4'd0, 16'h0000, {6{32'h00000000}}, 8'h00, 8'h00, 1'b1, ST_OK},
    '{1'b0, 4'd0, 16'hFFFF, {6{32'hFFFFFFFF}}, 8'h00, 8'h00, 1'b1, ST_OK},
    '{1'b0, 4'd1, 16'h0001, {6{32'h00000000}}, 8'h00, 8'hFF, 1'b1, ST_BAD_TAIL},
    '{1'b0, 4'd0, 16'h8000, {6{32'h00000000}}, 8'h01, 8'h00, 1'b1, ST_BAD_CSUM},
    '{1'b0, 4'd2, 16'h1234, {6{32'hFFFFFFFF}}, 8'h80, 8'h01, 1'b1, ST_BAD_TAIL},
    '{1'b0, 4'd0, 16'h5555, {6{32'h55555555}}, 8'h00, 8'h00, 1'b0, ST_OK},
    '{1'b1, 4'd3, 16'hA5C3, {32'h3F800000, 32'hBF800000, 32'h7F800000,
                             32'hFF800000, 32'h7FC00000, 32'h00000001},
      8'h00, 8'h00, 1'b0, ST_OK},
    '{1'b0, 4'd0, 16'h00FF, {32'h80000000, 32'h000000AA, 32'hAA000000,
                             32'h01020304, 32'hDEADBEEF, 32'h7FFFFFFF},
      8'hFF, 8'h00, 1'b0, ST_OK}
  };

  sensor_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[sensor_frame_deframer] ERROR");
    $finish;
  end

  task automatic deframe_byte(input logic [7:0] b);
    sfd_result_t r;
    int          off;
    if (fr_pos == POS_HUNT) begin
      if (b == hdr_val) begin
        fr_pos = POS_FIRST;
        fr_sum = '0;
      end
    end else begin
      if (fr_pos == POS_IDX_HI) begin
        fr_index[15:8] = b;
      end else if (fr_pos == POS_IDX_LO) begin
        fr_index[7:0] = b;
      end else if (fr_pos >= POS_WORD0 && fr_pos <= POS_WORDN) begin
        off = int'(fr_pos - POS_WORD0);
        fr_words[off / 4][8 * (off % 4) +: 8] = b;
        fr_sum = fr_sum + b;
      end else if (fr_pos == POS_CSUM) begin
        fr_csum = b;
      end
      if (fr_pos == POS_TAIL) begin
        r.frame_index = fr_index;
        r.words       = fr_words;
        if (b != tail_val)
          r.status = ST_BAD_TAIL;
        else if (fr_csum != fr_sum)
          r.status = ST_BAD_CSUM;
        else
          r.status = ST_OK;
        pending_frames.push_back(r);
        fr_pos = POS_HUNT;
      end else begin
        fr_pos = fr_pos + 1'b1;
      end
    end
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == hdr_val) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic [15:0] idx, input logic [5:0][31:0] words,
                            input logic [7:0] csum_delta, input logic [7:0] tail_flip);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    send_byte(hdr_val);
    send_byte(hdr_val);
    send_byte(8'(FRAME_LEN));
    send_byte(idx[15:8]);
    send_byte(idx[7:0]);
    for (int k = 0; k < 24; k++) begin
      b   = words[k / 4][8 * (k % 4) +: 8];
      sum = sum + b;
      send_byte(b);
    end
    send_byte(sum + csum_delta);
    send_byte(tail_val ^ tail_flip);
  endtask

  task automatic send_random_frame();
    logic [5:0][31:0] words;
    logic [7:0]       csum_delta;
    logic [7:0]       tail_flip;
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 7))
        0:       words[k] = '0;
        1:       words[k] = '1;
        default: words[k] = $urandom;
      endcase
    end
    csum_delta = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    tail_flip  = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_noise($urandom_range(0, 2));
    send_frame(16'($urandom_range(0, 65535)), words, csum_delta, tail_flip);
  endtask

  task automatic await_idle();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_HEADER)
      hdr_val = d;
    else if (idx == REG_TAIL)
      tail_val = d;
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] hdr, input logic [7:0] tail);
    await_idle();
    cfg_write(REG_HEADER, hdr);
    cfg_write(REG_TAIL, tail);
    // unmapped index, must leave both registers alone
    cfg_write(REG_TAIL + CFG_IDX_W'($urandom_range(1, 254)), 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int budget);
    int stop;
    int pick;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_random_frame();
      end else if (pick < 85) begin
        // truncated frame: the next header lands inside it as data
        send_byte(hdr_val);
        repeat ($urandom_range(0, 29)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    while (fr_pos != POS_HUNT) send_byte(8'($urandom_range(0, 255)));
  endtask

  // receiver
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0)
        hold_left = $urandom_range(1, 10);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    sfd_result_t got;
    sfd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sfd_result_t'({out_tuser, out_tdata});
      if (pending_frames.size() == 0) begin
        $error("result beat with none expected: frame_index %h", got.frame_index);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (got.frame_index !== want.frame_index) begin
          $error("frame_index: expected %h, got %h", want.frame_index, got.frame_index);
          mismatches++;
        end
        for (int k = 0; k < 6; k++) begin
          if (got.words[k] !== want.words[k]) begin
            $error("%s: expected %h, got %h", word_names[k], want.words[k], got.words[k]);
            mismatches++;
          end
        end
        if (got.status !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    sfd_result_t typed_frame;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].lead_tail) send_byte(tail_val);
      send_noise(int'(directed_rows[i].pre));
      send_frame(directed_rows[i].idx, directed_rows[i].words,
                 directed_rows[i].csum_delta, directed_rows[i].tail_flip);
      if (directed_rows[i].typed && pending_frames.size() != 0) begin
        typed_frame.frame_index = directed_rows[i].idx;
        typed_frame.words       = directed_rows[i].words;
        typed_frame.status      = directed_rows[i].status;
        pending_frames[pending_frames.size() - 1] = typed_frame;
      end
    end

    // back-pressure: receiver holds off while frames keep coming
    await_idle();
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    repeat (3) send_random_frame();
    await_idle();
    tx_idle_on = 1'b1;

    run_phase(70);
    reconfigure(8'h00, 8'hFF);
    run_phase(70);
    reconfigure(8'hFF, 8'h00);
    run_phase(70);
    reconfigure(8'h7E, 8'h7E);
    run_phase(70);
    reconfigure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(90);

    await_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_frames.size() == 0)
      $display("[sensor_frame_deframer] OK");
    else
      $display("[sensor_frame_deframer] ERROR");
    $finish;
  end

endmodule
